@@ rtl/core/sht_pkg.sv @@
// Package for the string-keyed hash table: request and response words,
// request and status codes, controller states and the ASCII case fold.
// No dependencies.
`default_nettype none

package sht_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_META,
        S_CMP,
        S_COPY
    } t_state;

    typedef struct packed {
        t_req_type   req_type;
        logic [7:0]  key_char;
        logic        key_last;
        logic [31:0] record_value;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [6:0]  slot_index;
        logic [31:0] found_value;
    } t_result;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/string_key_hash_table.sv @@
// A key byte that is not final gives no word. A final byte starts a walk through the key
// memory, one byte per cycle: insert copies the key into the slot and then gives its word;
// search and delete first check the slot's valid mark and length, then compare bytes. Too long key and clear:
// word in the next cycle. Clear then sweeps the slot table (busy high).
// Reset (synchronous, active low) starts the same sweep. Results are strobed
// for one cycle and cannot be stalled.
`default_nettype none

module string_key_hash_table
    import sht_pkg::*;
#(
    parameter int SLOTS       = 128,
    parameter int MAX_KEY_LEN = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_request i_req,
    output logic          busy,
    output logic          o_strobe,
    output t_result       o_rsp
);

    localparam int SW        = $clog2(SLOTS);
    localparam int IW        = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int LW        = $clog2(MAX_KEY_LEN + 1);
    localparam int KEY_DEPTH = SLOTS * (2 ** IW);

    typedef struct packed {
        logic                   valid;
        logic [LW-1:0]          len;
        logic [VALUE_WIDTH-1:0] rec;
    } t_meta;

    // memories
    logic [7:0] inc_mem  [MAX_KEY_LEN];
    logic [7:0] key_mem  [KEY_DEPTH];
    t_meta      meta_mem [SLOTS];

    // control registers
    t_state        r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [SW-1:0] r_sum, n_sum;
    logic          r_over, n_over;
    logic [LW-1:0] r_idx, n_idx;
    logic          r_chk, n_chk;
    logic [SW-1:0] r_sweep, n_sweep;
    logic          r_strobe, n_strobe;

    // payload registers
    logic [SW-1:0]          r_slot, n_slot;
    logic [LW-1:0]          r_klen, n_klen;
    t_req_type              r_req, n_req;
    logic [VALUE_WIDTH-1:0] r_rec, n_rec;
    logic [IW-1:0]          r_cidx, n_cidx;
    t_result                r_rsp, n_rsp;
    logic [7:0]             r_inc_q;
    logic [7:0]             r_key_q;
    t_meta                  r_meta_q;

    // memory port controls
    logic          inc_we;
    logic          key_we;
    logic          meta_we;
    logic [SW-1:0] meta_waddr;
    logic [SW-1:0] meta_raddr;
    t_meta         meta_wdata;

    // byte modulo SLOTS, one entry per byte value
    logic [SW-1:0] ch_mod_tbl [256];

    for (genvar g = 0; g < 256; g++) begin : g_mod_tbl
        assign ch_mod_tbl[g] = SW'(g % SLOTS);
    end

    logic [SW:0]   sum_wide;
    logic [SW-1:0] sum_next;
    logic          has_room;
    logic          bytes_differ;
    logic          all_issued;

    always_comb begin
        sum_wide = {1'b0, r_sum} + {1'b0, ch_mod_tbl[i_req.key_char]};
        if (sum_wide >= (SW + 1)'(SLOTS)) begin
            sum_next = SW'(sum_wide - (SW + 1)'(SLOTS));
        end else begin
            sum_next = sum_wide[SW-1:0];
        end
    end

    assign has_room     = (r_len < LW'(MAX_KEY_LEN));
    assign bytes_differ = (fold_case(r_inc_q) != fold_case(r_key_q));
    assign all_issued   = (r_idx == r_klen);

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_sum    = r_sum;
        n_over   = r_over;
        n_idx    = r_idx;
        n_chk    = r_chk;
        n_sweep  = r_sweep;
        n_strobe = 1'b0;
        n_slot   = r_slot;
        n_klen   = r_klen;
        n_req    = r_req;
        n_rec    = r_rec;
        n_cidx   = r_cidx;
        n_rsp    = r_rsp;

        inc_we     = 1'b0;
        key_we     = 1'b0;
        meta_we    = 1'b0;
        meta_waddr = r_slot;
        meta_raddr = r_slot;
        meta_wdata = r_meta_q;

        unique case (r_state)
            S_SWEEP: begin
                meta_we    = 1'b1;
                meta_waddr = r_sweep;
                meta_wdata = '0;
                n_sweep    = r_sweep + 1'b1;
                if (r_sweep == SW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                // look ahead at the slot a final byte would select
                meta_raddr = sum_next;
                if (start) begin
                    if (i_req.req_type == REQ_CLEAR) begin
                        n_len             = '0;
                        n_sum             = '0;
                        n_over            = 1'b0;
                        n_strobe          = 1'b1;
                        n_rsp.status      = ST_DONE;
                        n_rsp.slot_index  = '0;
                        n_rsp.found_value = '0;
                        n_sweep           = '0;
                        n_state           = S_SWEEP;
                    end else begin
                        inc_we = has_room;
                        if (has_room) begin
                            n_len = r_len + 1'b1;
                            n_sum = sum_next;
                        end else begin
                            n_over = 1'b1;
                        end
                        if (i_req.key_last) begin
                            n_len  = '0;
                            n_sum  = '0;
                            n_over = 1'b0;
                            n_idx  = '0;
                            n_chk  = 1'b0;
                            if (r_over || !has_room) begin
                                n_strobe          = 1'b1;
                                n_rsp.status      = ST_TOO_LONG;
                                n_rsp.slot_index  = '0;
                                n_rsp.found_value = '0;
                            end else begin
                                n_slot = sum_next;
                                n_klen = r_len + 1'b1;
                                n_req  = i_req.req_type;
                                n_rec  = VALUE_WIDTH'(i_req.record_value);
                                if (i_req.req_type == REQ_INSERT) begin
                                    n_state = S_COPY;
                                end else begin
                                    n_state = S_META;
                                end
                            end
                        end
                    end
                end
            end

            S_META: begin
                if (r_meta_q.valid && r_meta_q.len == r_klen) begin
                    n_state = S_CMP;
                end else begin
                    n_strobe          = 1'b1;
                    n_rsp.status      = ST_NOT_FOUND;
                    n_rsp.slot_index  = 7'(r_slot);
                    n_rsp.found_value = '0;
                    n_state           = S_IDLE;
                end
            end

            S_CMP: begin
                // issue one byte pair per cycle, compare it in the next cycle
                if (!all_issued) begin
                    n_idx = r_idx + 1'b1;
                    n_chk = 1'b1;
                end else begin
                    n_chk = 1'b0;
                end
                if (r_chk && bytes_differ) begin
                    n_strobe          = 1'b1;
                    n_rsp.status      = ST_NOT_FOUND;
                    n_rsp.slot_index  = 7'(r_slot);
                    n_rsp.found_value = '0;
                    n_state           = S_IDLE;
                end else if (!r_chk && all_issued) begin
                    n_strobe          = 1'b1;
                    n_rsp.status      = ST_FOUND;
                    n_rsp.slot_index  = 7'(r_slot);
                    n_rsp.found_value = 32'(r_meta_q.rec);
                    n_state           = S_IDLE;
                    if (r_req == REQ_DELETE) begin
                        meta_we          = 1'b1;
                        meta_wdata.valid = 1'b0;
                    end
                end
            end

            S_COPY: begin
                if (!all_issued) begin
                    n_idx  = r_idx + 1'b1;
                    n_chk  = 1'b1;
                    n_cidx = r_idx[IW-1:0];
                end else begin
                    n_chk = 1'b0;
                end
                key_we = r_chk;
                if (!r_chk && all_issued) begin
                    meta_we           = 1'b1;
                    meta_wdata.valid  = 1'b1;
                    meta_wdata.len    = r_klen;
                    meta_wdata.rec    = r_rec;
                    n_strobe          = 1'b1;
                    n_rsp.status      = ST_DONE;
                    n_rsp.slot_index  = 7'(r_slot);
                    n_rsp.found_value = '0;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_len    <= '0;
            r_sum    <= '0;
            r_over   <= 1'b0;
            r_idx    <= '0;
            r_chk    <= 1'b0;
            r_sweep  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_sum    <= n_sum;
            r_over   <= n_over;
            r_idx    <= n_idx;
            r_chk    <= n_chk;
            r_sweep  <= n_sweep;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_klen <= n_klen;
        r_req  <= n_req;
        r_rec  <= n_rec;
        r_cidx <= n_cidx;
        r_rsp  <= n_rsp;
    end

    // incoming key buffer
    always_ff @(posedge i_clk) begin
        if (inc_we) begin
            inc_mem[r_len[IW-1:0]] <= i_req.key_char;
        end
        r_inc_q <= inc_mem[r_idx[IW-1:0]];
    end

    // stored key bytes, one row of 2**IW bytes per slot
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[{r_slot, r_cidx}] <= r_inc_q;
        end
        r_key_q <= key_mem[{r_slot, r_idx[IW-1:0]}];
    end

    // slot valid mark, key length and record
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        r_meta_q <= meta_mem[meta_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/sht_checker.sv @@
// Port-level checks for string_key_hash_table, attached by bind.
// Depends on sht_pkg for the request and response words and their codes.
`default_nettype none

module sht_checker
    import sht_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     start,
    input wire t_request i_req,
    input wire logic     busy,
    input wire logic     o_strobe,
    input wire t_result  o_rsp
);

    // clear answers at once and then holds off new words during the sweep
    a_clear_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type == REQ_CLEAR) |=>
            (o_strobe && o_rsp.status == ST_DONE && o_rsp.slot_index == 7'd0
             && o_rsp.found_value == 32'd0 && busy))
        else $error("clear did not answer or did not start the sweep");

    // a byte that does not end its key gives no word
    a_no_word_mid_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type != REQ_CLEAR && !i_req.key_last) |=> !o_strobe)
        else $error("word issued for a key byte that is not final");

    a_value_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status != ST_FOUND) |-> (o_rsp.found_value == 32'd0))
        else $error("record value on a word that found nothing");

    a_too_long_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status == ST_TOO_LONG) |-> (o_rsp.slot_index == 7'd0))
        else $error("slot given for a key that is too long");

endmodule

bind string_key_hash_table sht_checker u_sht_checker (.*);

`default_nettype wire
